[rtl/dmacr_pkg.sv]
// Shared types, codes and constants of the DMA channel register block.
`default_nettype none
package dmacr_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [31:0] GOFS_CTRL  = 32'h00;
	localparam logic [31:0] GOFS_STAT  = 32'h04;
	localparam logic [31:0] GOFS_ISTAT = 32'h08;
	localparam logic [31:0] GOFS_ICLR  = 32'h0C;

	localparam logic [7:0] COFS_CTRL = 8'h00;
	localparam logic [7:0] COFS_STAT = 8'h04;
	localparam logic [7:0] COFS_SRC  = 8'h08;
	localparam logic [7:0] COFS_DST  = 8'h0C;
	localparam logic [7:0] COFS_REM  = 8'h10;
	localparam logic [7:0] COFS_SET  = 8'h14;

	localparam logic [2:0] G_NONE  = 3'd0;
	localparam logic [2:0] G_CTRL  = 3'd1;
	localparam logic [2:0] G_STAT  = 3'd2;
	localparam logic [2:0] G_ISTAT = 3'd3;
	localparam logic [2:0] G_ICLR  = 3'd4;

	localparam logic [2:0] W_CTRL = 3'd0;
	localparam logic [2:0] W_STAT = 3'd1;
	localparam logic [2:0] W_SRC  = 3'd2;
	localparam logic [2:0] W_DST  = 3'd3;
	localparam logic [2:0] W_REM  = 3'd4;
	localparam logic [2:0] W_SET  = 3'd5;
	localparam logic [2:0] W_NONE = 3'd7;

	localparam logic [31:0] EN_MASK      = 32'h0000_0001;
	localparam logic [31:0] DONE_MASK    = 32'h0000_0002;
	localparam logic [31:0] IRQ_EN_MASK  = 32'h0000_0100;
	localparam logic [31:0] DEFAULT_SIZE = 32'd1024;

	localparam int IRQ_W = 16;

	typedef struct packed {
		logic [2:0] glob;
		logic [2:0] word;
	} dec_t;

	typedef struct packed {
		logic        tick;
		logic        wr;
		logic [2:0]  word;
		logic [31:0] data;
	} chan_cmd_t;

	typedef struct packed {
		logic [31:0] ctrl;
		logic [31:0] stat;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] rem;
		logic [31:0] set;
	} chan_regs_t;

	function automatic logic [31:0] pick_word(chan_regs_t r, logic [2:0] w);
		logic [31:0] v;
		case (w)
			W_CTRL:  v = r.ctrl;
			W_STAT:  v = r.stat;
			W_SRC:   v = r.src;
			W_DST:   v = r.dst;
			W_REM:   v = r.rem;
			W_SET:   v = r.set;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/dmacr_ifs.sv]
// Channel interfaces of the DMA channel register block: request, response and configuration.
`default_nettype none
interface dmacr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] bus_addr;
	logic [31:0] write_data;

	modport source (output valid, opcode, bus_addr, write_data, input ready);
	modport sink (input valid, opcode, bus_addr, write_data, output ready);
endinterface

interface dmacr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [15:0] irq_mask;

	modport source (output valid, read_data, irq_mask, input ready);
	modport sink (input valid, read_data, irq_mask, output ready);
endinterface

interface dmacr_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_base;

	modport source (output valid, block_base, input ready);
	modport sink (input valid, block_base, output ready);
endinterface
`default_nettype wire

[rtl/dma_channel_register_block.sv]
// Top level of the DMA channel register block.
// The req channel carries one beat per bus read, bus write or clock tick
// (opcode 0, 1, 2); opcode 3 does nothing and still yields a beat.
// Every req beat produces exactly one rsp beat with read_data and irq_mask.
// The cfg channel sets block_base and is always ready; write it only while
// no req beat is outstanding.
// A req beat is captured in an input register and processed while the
// response register is free or being emptied: the address decode, the
// register update and the read mux sit between that register and the
// response register, which drives the rsp beat. A new req beat is taken
// every cycle as long as the response register is free or being emptied.
// When the receiver stalls, the response register holds its beat and the
// input register holds one more, after which req.ready drops.
// Reset clears every channel register, the global words, the interrupt
// status and block_base, and empties both registers.
`default_nettype none
module dma_channel_register_block #(
	parameter int CHANNEL_COUNT       = 16,
	parameter int CHANNEL_BASE_OFFSET = 256,
	parameter int CHANNEL_STRIDE      = 32
) (
	input wire logic     clk,
	input wire logic     arst_n,
	dmacr_req_if.sink    req,
	dmacr_rsp_if.source  rsp,
	dmacr_cfg_if.sink    cfg
);

	localparam int IRQ_N = (CHANNEL_COUNT < dmacr_pkg::IRQ_W) ? CHANNEL_COUNT
		: dmacr_pkg::IRQ_W;

	logic        v_s1;
	logic [1:0]  op_s1;
	logic [31:0] addr_s1;
	logic [31:0] data_s1;

	logic [31:0] base_q;
	logic [31:0] gctrl_q;
	logic [31:0] gstat_q;
	logic [15:0] istat_q;

	logic        rsp_valid_q;
	logic [31:0] rd_q;
	logic [15:0] irq_q;

	logic        out_free;
	logic        fire;
	logic        is_rd;
	logic        is_wr;
	logic        is_tick;
	logic        g_rd_hit;
	logic        g_wr_hit;

	dmacr_pkg::dec_t        dec;
	logic [CHANNEL_COUNT-1:0] chan_hit;
	dmacr_pkg::chan_cmd_t   cmd [CHANNEL_COUNT];
	dmacr_pkg::chan_regs_t  regs [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] chan_irq;

	logic [15:0] raised;
	logic [31:0] chan_rd;
	logic [31:0] rd_val;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = !v_s1 || out_free;
	assign fire      = v_s1 && out_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.opcode;
			addr_s1 <= req.bus_addr;
			data_s1 <= req.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			base_q <= cfg.block_base;
		end
	end

	dmacr_decode #(
		.CHANNEL_COUNT      (CHANNEL_COUNT),
		.CHANNEL_BASE_OFFSET(CHANNEL_BASE_OFFSET),
		.CHANNEL_STRIDE     (CHANNEL_STRIDE)
	) u_decode (
		.addr    (addr_s1),
		.base    (base_q),
		.dec     (dec),
		.chan_hit(chan_hit)
	);

	always_comb begin
		is_rd   = 1'b0;
		is_wr   = 1'b0;
		is_tick = 1'b0;
		unique case (op_s1)
			dmacr_pkg::OP_READ:  is_rd   = 1'b1;
			dmacr_pkg::OP_WRITE: is_wr   = 1'b1;
			dmacr_pkg::OP_TICK:  is_tick = 1'b1;
			default: ;
		endcase
	end

	assign g_rd_hit = (dec.glob == dmacr_pkg::G_CTRL) || (dec.glob == dmacr_pkg::G_STAT)
		|| (dec.glob == dmacr_pkg::G_ISTAT);
	assign g_wr_hit = (dec.glob == dmacr_pkg::G_CTRL) || (dec.glob == dmacr_pkg::G_STAT)
		|| (dec.glob == dmacr_pkg::G_ICLR);

	for (genvar n = 0; n < CHANNEL_COUNT; n++) begin : g_chan
		assign cmd[n].tick = fire && is_tick;
		assign cmd[n].wr   = fire && is_wr && !g_wr_hit && chan_hit[n];
		assign cmd[n].word = dec.word;
		assign cmd[n].data = data_s1;

		dmacr_chan u_chan (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd[n]),
			.regs  (regs[n]),
			.irq   (chan_irq[n])
		);
	end

	always_comb begin
		raised = '0;
		for (int n = 0; n < IRQ_N; n++) begin
			raised[n] = chan_irq[n];
		end
	end

	always_comb begin
		chan_rd = '0;
		for (int n = 0; n < CHANNEL_COUNT; n++) begin
			if (chan_hit[n]) begin
				chan_rd = chan_rd | dmacr_pkg::pick_word(regs[n], dec.word);
			end
		end
	end

	always_comb begin
		rd_val = '0;
		if (is_rd) begin
			unique case (dec.glob)
				dmacr_pkg::G_CTRL:  rd_val = gctrl_q;
				dmacr_pkg::G_STAT:  rd_val = gstat_q;
				dmacr_pkg::G_ISTAT: rd_val = {16'b0, istat_q};
				default:            rd_val = chan_rd;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gctrl_q <= '0;
			gstat_q <= '0;
			istat_q <= '0;
		end else if (fire) begin
			if (is_tick) begin
				istat_q <= istat_q | raised;
			end else if (is_wr && g_wr_hit) begin
				unique case (dec.glob)
					dmacr_pkg::G_CTRL: gctrl_q <= data_s1;
					dmacr_pkg::G_STAT: gstat_q <= data_s1;
					dmacr_pkg::G_ICLR: istat_q <= istat_q & ~data_s1[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q  <= (g_rd_hit || is_rd) ? rd_val : '0;
			irq_q <= is_tick ? raised : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rd_q;
	assign rsp.irq_mask  = irq_q;

endmodule
`default_nettype wire

[rtl/dmacr_decode.sv]
// Address decoder that maps a bus address to a global word or a channel word.
`default_nettype none
module dmacr_decode #(
	parameter int CHANNEL_COUNT       = 16,
	parameter int CHANNEL_BASE_OFFSET = 256,
	parameter int CHANNEL_STRIDE      = 32
) (
	input  wire logic [31:0]              addr,
	input  wire logic [31:0]              base,
	output dmacr_pkg::dec_t               dec,
	output logic [CHANNEL_COUNT-1:0]      chan_hit
);

	localparam int SPAN   = CHANNEL_COUNT * CHANNEL_STRIDE;
	localparam int SPAN_W = $clog2(SPAN);
	localparam int OFS_W  = $clog2(CHANNEL_STRIDE);

	logic [31:0]       rel;
	logic [31:0]       crel;
	logic              in_win;
	logic [SPAN_W-1:0] low;
	logic [OFS_W-1:0]  ofs_n [CHANNEL_COUNT];
	logic [OFS_W-1:0]  ofs;

	assign rel    = addr - base;
	assign crel   = rel - 32'(CHANNEL_BASE_OFFSET);
	assign in_win = crel < 32'(SPAN);
	assign low    = crel[SPAN_W-1:0];

	for (genvar n = 0; n < CHANNEL_COUNT; n++) begin : g_win
		localparam logic [SPAN_W:0] LO = (SPAN_W+1)'(n * CHANNEL_STRIDE);
		localparam logic [SPAN_W:0] HI = (SPAN_W+1)'((n + 1) * CHANNEL_STRIDE);
		logic [SPAN_W:0] diff;
		assign diff        = {1'b0, low} - LO;
		assign chan_hit[n] = in_win && ({1'b0, low} >= LO) && ({1'b0, low} < HI);
		assign ofs_n[n]    = diff[OFS_W-1:0];
	end

	always_comb begin
		ofs = '0;
		for (int n = 0; n < CHANNEL_COUNT; n++) begin
			if (chan_hit[n]) begin
				ofs = ofs | ofs_n[n];
			end
		end
	end

	always_comb begin
		unique case (rel)
			dmacr_pkg::GOFS_CTRL:  dec.glob = dmacr_pkg::G_CTRL;
			dmacr_pkg::GOFS_STAT:  dec.glob = dmacr_pkg::G_STAT;
			dmacr_pkg::GOFS_ISTAT: dec.glob = dmacr_pkg::G_ISTAT;
			dmacr_pkg::GOFS_ICLR:  dec.glob = dmacr_pkg::G_ICLR;
			default:               dec.glob = dmacr_pkg::G_NONE;
		endcase
	end

	always_comb begin
		if (ofs == OFS_W'(dmacr_pkg::COFS_CTRL)) begin
			dec.word = dmacr_pkg::W_CTRL;
		end else if (ofs == OFS_W'(dmacr_pkg::COFS_STAT)) begin
			dec.word = dmacr_pkg::W_STAT;
		end else if (ofs == OFS_W'(dmacr_pkg::COFS_SRC)) begin
			dec.word = dmacr_pkg::W_SRC;
		end else if (ofs == OFS_W'(dmacr_pkg::COFS_DST)) begin
			dec.word = dmacr_pkg::W_DST;
		end else if (ofs == OFS_W'(dmacr_pkg::COFS_REM)) begin
			dec.word = dmacr_pkg::W_REM;
		end else if (ofs == OFS_W'(dmacr_pkg::COFS_SET)) begin
			dec.word = dmacr_pkg::W_SET;
		end else begin
			dec.word = dmacr_pkg::W_NONE;
		end
	end

endmodule
`default_nettype wire

[rtl/dmacr_chan.sv]
// One DMA channel: its six registers, bus writes and the tick countdown.
`default_nettype none
module dmacr_chan (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dmacr_pkg::chan_cmd_t  cmd,
	output dmacr_pkg::chan_regs_t      regs,
	output logic                       irq
);

	logic [31:0] ctrl_q;
	logic [31:0] stat_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [31:0] rem_q;
	logic [31:0] set_q;
	logic        active;
	logic        last;

	assign active = ((ctrl_q & dmacr_pkg::EN_MASK) != '0) && (rem_q != '0);
	assign last   = active && (rem_q == 32'd1);
	assign irq    = cmd.tick && last && ((set_q & dmacr_pkg::IRQ_EN_MASK) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			stat_q <= '0;
			src_q  <= '0;
			dst_q  <= '0;
			rem_q  <= '0;
			set_q  <= '0;
		end else if (cmd.tick) begin
			if (active) begin
				rem_q <= rem_q - 32'd1;
				if (last) begin
					ctrl_q <= ctrl_q & ~dmacr_pkg::EN_MASK;
					stat_q <= stat_q | dmacr_pkg::DONE_MASK;
				end
			end
		end else if (cmd.wr) begin
			unique case (cmd.word)
				dmacr_pkg::W_CTRL: begin
					ctrl_q <= cmd.data;
					if (((cmd.data & dmacr_pkg::EN_MASK) != '0) && (rem_q == '0)) begin
						rem_q <= dmacr_pkg::DEFAULT_SIZE;
					end
				end
				dmacr_pkg::W_STAT: stat_q <= cmd.data;
				dmacr_pkg::W_SRC:  src_q  <= cmd.data;
				dmacr_pkg::W_DST:  dst_q  <= cmd.data;
				dmacr_pkg::W_REM:  rem_q  <= cmd.data;
				dmacr_pkg::W_SET:  set_q  <= cmd.data;
				default: ;
			endcase
		end
	end

	assign regs.ctrl = ctrl_q;
	assign regs.stat = stat_q;
	assign regs.src  = src_q;
	assign regs.dst  = dst_q;
	assign regs.rem  = rem_q;
	assign regs.set  = set_q;

endmodule
`default_nettype wire

[rtl/dmacr_checker.sv]
// Port-level checker of the DMA channel register block and its bind statement.
`default_nettype none
module dmacr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_read_data,
	input wire logic [15:0] rsp_irq_mask,
	input wire logic        cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
			&& $stable(rsp_irq_mask))
		else $error("Stalled response beat changed or vanished.");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_irq_mask == '0) || (rsp_read_data == '0))
		else $error("Response beat carries both read data and interrupts.");

	a_req_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("Request channel stalled without a stalled response.");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid || !req_valid |-> cfg_ready)
		else $error("Configuration channel was not ready.");

endmodule

bind dma_channel_register_block dmacr_checker u_dmacr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_read_data(rsp.read_data),
	.rsp_irq_mask (rsp.irq_mask),
	.cfg_ready    (cfg.ready)
);
`default_nettype wire
